// ----- hdl/bia_pkg.sv -----
package bia_pkg;

  // Map geometry; the field widths of the command interface follow from it
  localparam int MAP_BITS   = 4096;
  localparam int WORD_BITS  = 32;
  localparam int NUM_WORDS  = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int ID_W       = $clog2(MAP_BITS);
  localparam int CNT_W      = ID_W + 1;
  localparam int WADDR_W    = $clog2(NUM_WORDS);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int POP_W      = BIT_W + 1;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = CNT_W;

  localparam logic [CFG_IDX_W-1:0] CFG_IDS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVALID_ID = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_LOAD    = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_NO_SPACE     = 3'd1,
    ST_HINT_USED    = 3'd2,
    ST_INVALID      = 3'd3,
    ST_ALREADY_FREE = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_RD_ITEM,
    OP_ALLOC,
    OP_RELEASE,
    OP_LOAD_CNT,
    OP_LOAD_WR,
    OP_SCAN_RD,
    OP_SCAN_NEXT,
    OP_SCAN_HIT,
    OP_SCAN_END
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    logic    finish;
    status_e status;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic alloc_fail;
    logic rel_bad;
    logic item_bit;
    logic scan_past;
    logic zero_found;
    logic last_word;
  } dp_flags_t;

endpackage

// ----- hdl/bia_ram.sv -----
module bia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/bia_ctrl.sv -----
module bia_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output logic               done_o,
  input  bia_pkg::dp_flags_t flags_i,
  output bia_pkg::dp_cmd_t   dp_cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CHECK,
    S_LOAD_WR,
    S_SCAN_START,
    S_SCAN
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d         = state_q;
    done_d          = 1'b0;
    dp_cmd_o.op     = bia_pkg::OP_NONE;
    dp_cmd_o.finish = 1'b0;
    dp_cmd_o.status = bia_pkg::ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          dp_cmd_o.op = bia_pkg::OP_LATCH;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (flags_i.cmd)
          bia_pkg::CMD_ALLOC: begin
            if (flags_i.alloc_fail) begin
              dp_cmd_o.finish = 1'b1;
              dp_cmd_o.status = bia_pkg::ST_NO_SPACE;
            end else begin
              dp_cmd_o.op = bia_pkg::OP_RD_ITEM;
              state_d     = S_CHECK;
            end
          end
          bia_pkg::CMD_RELEASE: begin
            if (flags_i.rel_bad) begin
              dp_cmd_o.finish = 1'b1;
              dp_cmd_o.status = bia_pkg::ST_INVALID;
            end else begin
              dp_cmd_o.op = bia_pkg::OP_RD_ITEM;
              state_d     = S_CHECK;
            end
          end
          bia_pkg::CMD_LOAD: begin
            dp_cmd_o.op = bia_pkg::OP_RD_ITEM;
            state_d     = S_CHECK;
          end
          bia_pkg::CMD_NOP: begin
            dp_cmd_o.finish = 1'b1;
          end
          default: begin
            dp_cmd_o.finish = 1'b1;
          end
        endcase
      end
      S_CHECK: begin
        unique case (flags_i.cmd)
          bia_pkg::CMD_ALLOC: begin
            if (flags_i.item_bit) begin
              dp_cmd_o.finish = 1'b1;
              dp_cmd_o.status = bia_pkg::ST_HINT_USED;
            end else begin
              dp_cmd_o.op = bia_pkg::OP_ALLOC;
              state_d     = S_SCAN_START;
            end
          end
          bia_pkg::CMD_RELEASE: begin
            dp_cmd_o.finish = 1'b1;
            if (flags_i.item_bit) begin
              dp_cmd_o.op = bia_pkg::OP_RELEASE;
            end else begin
              dp_cmd_o.status = bia_pkg::ST_ALREADY_FREE;
            end
          end
          bia_pkg::CMD_LOAD: begin
            dp_cmd_o.op = bia_pkg::OP_LOAD_CNT;
            state_d     = S_LOAD_WR;
          end
          default: begin
            dp_cmd_o.finish = 1'b1;
          end
        endcase
      end
      S_LOAD_WR: begin
        dp_cmd_o.op = bia_pkg::OP_LOAD_WR;
        state_d     = S_SCAN_START;
      end
      S_SCAN_START: begin
        if (flags_i.scan_past) begin
          dp_cmd_o.op     = bia_pkg::OP_SCAN_END;
          dp_cmd_o.finish = 1'b1;
        end else begin
          dp_cmd_o.op = bia_pkg::OP_SCAN_RD;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (flags_i.zero_found) begin
          dp_cmd_o.op     = bia_pkg::OP_SCAN_HIT;
          dp_cmd_o.finish = 1'b1;
        end else if (flags_i.last_word) begin
          dp_cmd_o.op     = bia_pkg::OP_SCAN_END;
          dp_cmd_o.finish = 1'b1;
        end else begin
          dp_cmd_o.op = bia_pkg::OP_SCAN_NEXT;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (dp_cmd_o.finish) begin
      done_d  = 1'b1;
      state_d = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

`ifndef NO_ASSERTIONS
  a_done_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE)
    else $error("result strobe while a command is still running");

  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start) |=> state_q == S_DECODE)
    else $error("accepted transaction did not enter decode");

  a_scan_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && !flags_i.zero_found && !flags_i.last_word)
      |=> (state_q == S_SCAN && !done_q))
    else $error("scan stopped before a free id or the map end");
`endif

endmodule

// ----- hdl/bia_datapath.sv -----
module bia_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bia_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bia_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [bia_pkg::CMD_W-1:0]          cmd_i,
  input  logic [bia_pkg::ID_W-1:0]           node_id_i,
  input  logic [bia_pkg::WADDR_W-1:0]        word_index_i,
  input  logic [bia_pkg::WORD_BITS-1:0]      word_data_i,
  input  bia_pkg::dp_cmd_t                   dp_cmd_i,
  output bia_pkg::dp_flags_t                 flags_o,
  output logic [bia_pkg::STATUS_W-1:0]       status_o,
  output logic [bia_pkg::ID_W-1:0]           granted_id_o,
  output logic [bia_pkg::CNT_W-1:0]          free_left_o,
  output logic [bia_pkg::CNT_W-1:0]          lowest_free_o
);

  localparam int WB  = bia_pkg::WORD_BITS;
  localparam int IW  = bia_pkg::ID_W;
  localparam int CW  = bia_pkg::CNT_W;
  localparam int AW  = bia_pkg::WADDR_W;
  localparam int BW  = bia_pkg::BIT_W;
  localparam int PW  = bia_pkg::POP_W;
  localparam int NW  = bia_pkg::NUM_WORDS;

  // Mask of the bits of word w whose ids lie below lim
  function automatic logic [WB-1:0] up_mask(input logic [AW-1:0] w, input logic [CW-1:0] lim);
    logic [CW-1:0] base;
    logic [CW-1:0] rem;
    logic [WB-1:0] m;
    base = {1'b0, w, {BW{1'b0}}};
    rem  = lim - base;
    if (lim <= base) begin
      m = '0;
    end else if (rem >= CW'(WB)) begin
      m = '1;
    end else begin
      m = (WB'(1) << rem[BW-1:0]) - WB'(1);
    end
    return m;
  endfunction

  function automatic logic [PW-1:0] popcount(input logic [WB-1:0] v);
    logic [PW-1:0] n;
    n = '0;
    for (int i = 0; i < WB; i++) begin
      n = n + PW'(v[i]);
    end
    return n;
  endfunction

  // Configuration and map state
  logic [CW-1:0]        ids_q;
  logic [IW-1:0]        inv_q;
  logic [CW-1:0]        count_q;
  logic [CW-1:0]        hint_q;
  logic [NW-1:0]        valid_q;
  logic                 rvalid_q;

  // Latched transaction and scan payload
  bia_pkg::cmd_e        cmd_q;
  logic [IW-1:0]        id_q;
  logic [AW-1:0]        widx_q;
  logic [WB-1:0]        wdata_q;
  logic [IW-1:0]        granted_q;
  bia_pkg::status_e     status_q;
  logic [CW-1:0]        scan_pos_q;
  logic [AW-1:0]        scan_word_q;
  logic [PW-1:0]        old_n_q;
  logic [PW-1:0]        new_n_q;

  logic [CW-1:0]        bits;
  logic [WB-1:0]        ram_rdata;
  logic [WB-1:0]        word_rd;
  logic [BW-1:0]        item_off;
  logic [AW-1:0]        item_word;
  logic [WB-1:0]        item_mask;
  logic [WB-1:0]        lo_mask;
  logic [WB-1:0]        cand;
  logic [BW-1:0]        hit_idx;
  logic [AW:0]          next_word;
  logic [CW-1:0]        next_base;
  logic [WB-1:0]        load_mask;
  logic [CW+1:0]        fc_sum;
  logic [CW-1:0]        fc;
  logic                 re;
  logic [AW-1:0]        raddr;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [WB-1:0]        wdata;

  assign bits = (ids_q > CW'(bia_pkg::MAP_BITS)) ? CW'(bia_pkg::MAP_BITS) : ids_q;

  // Words that were never written since reset read as all free
  assign word_rd   = rvalid_q ? ram_rdata : '0;
  assign item_off  = (cmd_q == bia_pkg::CMD_RELEASE) ? id_q[BW-1:0] : hint_q[BW-1:0];
  assign item_word = (cmd_q == bia_pkg::CMD_RELEASE) ? id_q[IW-1:BW] : hint_q[IW-1:BW];
  assign item_mask = WB'(1) << item_off;

  assign lo_mask   = (scan_word_q == scan_pos_q[IW-1:BW]) ? ('1 << scan_pos_q[BW-1:0]) : '1;
  assign cand      = ~word_rd & lo_mask & up_mask(scan_word_q, bits);
  assign next_word = {1'b0, scan_word_q} + (AW+1)'(1);
  assign next_base = {next_word, {BW{1'b0}}};
  assign load_mask = up_mask(widx_q, bits);

  always_comb begin
    hit_idx = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit_idx = BW'(i);
      end
    end
  end

  // Free count after a load, held between zero and the valid id count
  always_comb begin
    fc_sum = {2'b00, count_q} + (CW+2)'(old_n_q) - (CW+2)'(new_n_q);
    priority if (fc_sum[CW+1]) begin
      fc = '0;
    end else if (fc_sum[CW:0] > {1'b0, bits}) begin
      fc = bits;
    end else begin
      fc = fc_sum[CW-1:0];
    end
  end

  always_comb begin
    flags_o.cmd        = cmd_q;
    flags_o.alloc_fail = (count_q == '0) || (hint_q >= bits);
    flags_o.rel_bad    = (id_q == inv_q) || ({1'b0, id_q} >= bits);
    flags_o.item_bit   = |(word_rd & item_mask);
    flags_o.scan_past  = (scan_pos_q >= bits);
    flags_o.zero_found = |cand;
    flags_o.last_word  = (next_base >= bits);
  end

  // Memory port steering
  always_comb begin
    re    = 1'b0;
    raddr = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    unique case (dp_cmd_i.op)
      bia_pkg::OP_RD_ITEM: begin
        re    = 1'b1;
        raddr = (cmd_q == bia_pkg::CMD_LOAD) ? widx_q : item_word;
      end
      bia_pkg::OP_SCAN_RD: begin
        re    = 1'b1;
        raddr = scan_pos_q[IW-1:BW];
      end
      bia_pkg::OP_SCAN_NEXT: begin
        re    = 1'b1;
        raddr = next_word[AW-1:0];
      end
      bia_pkg::OP_ALLOC: begin
        we    = 1'b1;
        waddr = item_word;
        wdata = word_rd | item_mask;
      end
      bia_pkg::OP_RELEASE: begin
        we    = 1'b1;
        waddr = item_word;
        wdata = word_rd & ~item_mask;
      end
      bia_pkg::OP_LOAD_WR: begin
        we    = 1'b1;
        waddr = widx_q;
        wdata = wdata_q;
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  bia_ram #(
    .WIDTH (WB),
    .DEPTH (NW)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ids_q    <= CW'(bia_pkg::MAP_BITS);
      inv_q    <= '0;
      count_q  <= CW'(bia_pkg::MAP_BITS);
      hint_q   <= '0;
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == bia_pkg::CFG_IDS_IN_USE) begin
          ids_q <= cfg_data_i[CW-1:0];
        end else begin
          inv_q <= cfg_data_i[IW-1:0];
        end
      end
      if (re) begin
        rvalid_q <= valid_q[raddr];
      end
      if (we) begin
        valid_q[waddr] <= 1'b1;
      end
      unique case (dp_cmd_i.op)
        bia_pkg::OP_ALLOC: begin
          count_q <= count_q - CW'(1);
        end
        bia_pkg::OP_RELEASE: begin
          if (hint_q > {1'b0, id_q}) begin
            hint_q <= {1'b0, id_q};
          end
          if (count_q < bits) begin
            count_q <= count_q + CW'(1);
          end
        end
        bia_pkg::OP_LOAD_WR: begin
          count_q <= fc;
        end
        bia_pkg::OP_SCAN_HIT: begin
          hint_q <= {1'b0, scan_word_q, hit_idx};
        end
        bia_pkg::OP_SCAN_END: begin
          hint_q <= bits;
        end
        default: begin
          hint_q <= hint_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (dp_cmd_i.op)
      bia_pkg::OP_LATCH: begin
        cmd_q     <= bia_pkg::cmd_e'(cmd_i);
        id_q      <= node_id_i;
        widx_q    <= word_index_i;
        wdata_q   <= word_data_i;
        granted_q <= '0;
      end
      bia_pkg::OP_ALLOC: begin
        granted_q  <= hint_q[IW-1:0];
        scan_pos_q <= hint_q + CW'(1);
      end
      bia_pkg::OP_LOAD_CNT: begin
        old_n_q <= popcount(word_rd & load_mask);
        new_n_q <= popcount(wdata_q & load_mask);
      end
      bia_pkg::OP_LOAD_WR: begin
        scan_pos_q <= '0;
      end
      bia_pkg::OP_SCAN_RD: begin
        scan_word_q <= scan_pos_q[IW-1:BW];
      end
      bia_pkg::OP_SCAN_NEXT: begin
        scan_word_q <= next_word[AW-1:0];
      end
      default: begin
        scan_word_q <= scan_word_q;
      end
    endcase
    if (dp_cmd_i.finish) begin
      status_q <= dp_cmd_i.status;
    end
  end

  assign status_o      = status_q;
  assign granted_id_o  = granted_q;
  assign free_left_o   = count_q;
  assign lowest_free_o = hint_q;

endmodule

// ----- hdl/bitmap_id_allocator_top.sv -----
// No space, invalid id and an unused code finish in decode; a release or a used hinted id finishes
// after its word is read, and allocate and load go on to scan the bitmap for the lowest free id.
// One command at a time: the next is taken at the result edge, and the free-id scan, one 32-bit
// word per cycle, sets the cost of allocate and load. Reset (async, active low) clears the map
// at once through per-word valid bits, so commands are taken right after reset; results are
// strobed for one cycle, never stalled.
module bitmap_id_allocator_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  // Configuration write port
  input  logic                           cfg_we_i,
  input  logic [bia_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bia_pkg::CFG_DATA_W-1:0] cfg_data_i,

  // Command transaction
  input  logic                           start,
  output logic                           busy,
  input  logic [bia_pkg::CMD_W-1:0]      cmd_i,
  input  logic [bia_pkg::ID_W-1:0]       node_id_i,
  input  logic [bia_pkg::WADDR_W-1:0]    word_index_i,
  input  logic [bia_pkg::WORD_BITS-1:0]  word_data_i,

  // Result transaction, valid for the single cycle that done_o is high
  output logic                           done_o,
  output logic [bia_pkg::STATUS_W-1:0]   status_o,
  output logic [bia_pkg::ID_W-1:0]       granted_id_o,
  output logic [bia_pkg::CNT_W-1:0]      free_left_o,
  output logic [bia_pkg::CNT_W-1:0]      lowest_free_o
);

  // The controller sequences each command: decode the early rejects, read the
  // addressed bitmap word, modify or count it, then walk the map for the lowest
  // free id. The datapath holds the bitmap RAM, the free count, the hint and the
  // configuration, and reports the conditions the controller branches on.
  bia_pkg::dp_cmd_t   dp_cmd;
  bia_pkg::dp_flags_t dp_flags;

  bia_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .done_o   (done_o),
    .flags_i  (dp_flags),
    .dp_cmd_o (dp_cmd)
  );

  // Hold free_left and lowest_free on the live state registers: they only move
  // while a command runs, so they are stable for the cycle the strobe is high.
  bia_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd_i),
    .node_id_i     (node_id_i),
    .word_index_i  (word_index_i),
    .word_data_i   (word_data_i),
    .dp_cmd_i      (dp_cmd),
    .flags_o       (dp_flags),
    .status_o      (status_o),
    .granted_id_o  (granted_id_o),
    .free_left_o   (free_left_o),
    .lowest_free_o (lowest_free_o)
  );

endmodule
